// ----- sv/ils_pkg.sv -----
// ----------------------------------------------------------------------------
// ils_pkg: shared types and constants for the indexed list shift engine
// Request and result items, operation and status codes, cell control group.
// ----------------------------------------------------------------------------
package ils_pkg;

   localparam int DEF_CAPACITY   = 16;
   localparam int DEF_DATA_WIDTH = 32;
   localparam int MAX_DATA_WIDTH = 64;

   localparam int OP_WIDTH     = 2;
   localparam int POS_WIDTH    = 4;
   localparam int ELEM_WIDTH   = 32;
   localparam int STATUS_WIDTH = 2;
   localparam int COUNT_WIDTH  = 5;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_APPEND = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0]   operation;
      logic [POS_WIDTH-1:0]  position;
      logic [ELEM_WIDTH-1:0] element;
   } req_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic [ELEM_WIDTH-1:0]   read_value;
      logic [COUNT_WIDTH-1:0]  entry_count;
   } rsp_type;

   // broadcast to every cell; at most one flag is set
   typedef struct packed {
      logic append;
      logic insert;
      logic remove;
   } cell_ctl_type;

endpackage

// ----- sv/ils_cell.sv -----
// ----------------------------------------------------------------------------
// ils_cell: one list slot
// Holds one entry; loads the new word, its left or right neighbor, or holds.
// Passes a readout OR chain on to the next cell.
// ----------------------------------------------------------------------------
module ils_cell import ils_pkg::*; #(
   parameter int DATA_WIDTH = DEF_DATA_WIDTH,
   parameter int KEY_WIDTH  = 5,
   parameter int CELL_INDEX = 0
) (
   input  logic                  clock,
   input  cell_ctl_type          ctl,
   input  logic [KEY_WIDTH-1:0]  pos_k,
   input  logic [KEY_WIDTH-1:0]  count_k,
   input  logic [DATA_WIDTH-1:0] word,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic [DATA_WIDTH-1:0] right_data,
   input  logic [DATA_WIDTH-1:0] acc_in,
   output logic [DATA_WIDTH-1:0] data_out,
   output logic [DATA_WIDTH-1:0] acc_out
);

   localparam logic [KEY_WIDTH-1:0] IDX      = KEY_WIDTH'(CELL_INDEX);
   localparam logic [KEY_WIDTH-1:0] IDX_NEXT = KEY_WIDTH'(CELL_INDEX + 1);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic                  hit;

   assign hit = (pos_k == IDX);

   always_comb begin
      data_in = data_ff;
      priority if (ctl.append && (IDX == count_k)) begin
         data_in = word;
      end else if (ctl.insert && hit) begin
         data_in = word;
      end else if (ctl.insert && (IDX > pos_k) && (IDX <= count_k)) begin
         data_in = left_data;
      end else if (ctl.remove && (IDX >= pos_k) && (IDX_NEXT < count_k)) begin
         data_in = right_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign acc_out  = acc_in | (hit ? data_ff : '0);

endmodule

// ----- sv/indexed_list_shift_engine.sv -----
// ----------------------------------------------------------------------------
// indexed_list_shift_engine: ordered list with insert/remove at an index
// Append, insert, remove and read on a list of up to CAPACITY words.
// ----------------------------------------------------------------------------
// Each item is accepted when start is high and busy is low, and its result
// appears on rsp_item with rsp_strobe high in the following
// cycle. A new item may be started in every cycle. The list is a row of
// cells that all shift together in the accepting cycle, so insert and remove
// cost the same as append; the read path is an OR chain running through the
// cells. Busy is high only while reset is asserted. The receiver cannot stall.
// ----------------------------------------------------------------------------
module indexed_list_shift_engine import ils_pkg::*; #(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int KW = (CW > POS_WIDTH) ? CW : POS_WIDTH;
   localparam logic [KW-1:0] CAP_K = KW'(CAPACITY);

   logic                  accept;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic [KW-1:0]         count_k;
   logic [KW-1:0]         pos_k;
   logic [MAX_DATA_WIDTH-1:0] word_wide;
   logic [MAX_DATA_WIDTH-1:0] rd_wide;
   logic [DATA_WIDTH-1:0] word;
   cell_ctl_type          ctl;
   status_type            status;
   logic                  take_value;
   logic                  rsp_strobe_ff;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
   logic [DATA_WIDTH-1:0] acc       [CAPACITY+1];

   assign busy    = reset;
   assign accept  = start && !busy;
   assign count_k = KW'(count_ff);
   assign pos_k   = KW'(req_item.position);

   assign word_wide = MAX_DATA_WIDTH'(req_item.element);
   assign word      = word_wide[DATA_WIDTH-1:0];

   always_comb begin
      status     = ST_DONE;
      take_value = 1'b0;
      unique case (op_type'(req_item.operation))
         OP_APPEND: begin
            if (count_k >= CAP_K) status = ST_FULL;
         end
         OP_INSERT: begin
            priority if (pos_k >= count_k) status = ST_RANGE;
            else if (count_k >= CAP_K) status = ST_FULL;
            else status = ST_DONE;
         end
         OP_REMOVE, OP_READ: begin
            if (pos_k >= count_k) status = ST_RANGE;
            else take_value = 1'b1;
         end
         default: status = ST_DONE;
      endcase
   end

   always_comb begin
      ctl.append = accept && (status == ST_DONE) && (req_item.operation == OP_APPEND);
      ctl.insert = accept && (status == ST_DONE) && (req_item.operation == OP_INSERT);
      ctl.remove = accept && (status == ST_DONE) && (req_item.operation == OP_REMOVE);
   end

   always_comb begin
      priority if (ctl.append || ctl.insert) count_in = count_ff + CW'(1);
      else if (ctl.remove) count_in = count_ff - CW'(1);
      else count_in = count_ff;
   end

   assign acc[0] = '0;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      ils_cell #(
         .DATA_WIDTH(DATA_WIDTH),
         .KEY_WIDTH (KW),
         .CELL_INDEX(g)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .pos_k     (pos_k),
         .count_k   (count_k),
         .word      (word),
         .left_data ((g == 0) ? '0 : cell_data[(g == 0) ? 0 : g - 1]),
         .right_data((g == CAPACITY - 1) ? '0 : cell_data[(g == CAPACITY - 1) ? g : g + 1]),
         .acc_in    (acc[g]),
         .data_out  (cell_data[g]),
         .acc_out   (acc[g+1])
      );
   end

   assign rd_wide = MAX_DATA_WIDTH'(acc[CAPACITY]);

   always_comb begin
      rsp_in.status      = status;
      rsp_in.read_value  = take_value ? rd_wide[ELEM_WIDTH-1:0] : '0;
      rsp_in.entry_count = COUNT_WIDTH'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      KW'(count_ff) <= CAP_K)
      else $error("entry count above capacity");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("item without result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("result without item");

   a_error_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && (status != ST_DONE)) |=> (count_ff == $past(count_ff)))
      else $error("rejected item changed the list");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.status != ST_DONE)) |-> (rsp_item.read_value == '0))
      else $error("nonzero value on error");

endmodule
